FILE: rtl/core/lcca_pkg.sv
// Package for the laser color channel adjust unit.
// Shared types, field widths, register indexes and arithmetic constants.
// No dependencies.
package lcca_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int PIX_W     = 8;   // color component and drive value width
    localparam int MIX_W     = 10;  // mixed channel in half units, at most 1020
    localparam int RATIO_W   = 9;
    localparam int CFG_IDX_W = 3;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 9'd256;
    localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;

    // Luminance weights per mille.
    localparam logic [9:0] LUMA_R = 10'd299;
    localparam logic [9:0] LUMA_G = 10'd587;
    localparam logic [9:0] LUMA_B = 10'd114;

    // Division by 1000 as multiply by ceil(2^28 / 1000) and shift. Exact for
    // every quotient input below the saturation bound.
    localparam int               QUO_W     = 18;
    localparam int               RECIP_W   = 19;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 19'd268436;
    localparam int               DIV_SHIFT = 28;
    localparam logic [QUO_W-1:0] DIV_SAT   = 18'd256000;

    localparam int QUEUE_DEPTH   = 2;
    localparam int BACK_STAGES   = 5;
    localparam int PIPE_CAPACITY = 1 + QUEUE_DEPTH + BACK_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EN_RED     = 3'd0,
        CFG_EN_GREEN   = 3'd1,
        CFG_EN_BLUE    = 3'd2,
        CFG_ANALOG     = 3'd3,
        CFG_GAIN_RED   = 3'd4,
        CFG_GAIN_GREEN = 3'd5,
        CFG_GAIN_BLUE  = 3'd6,
        CFG_RATIO      = 3'd7
    } t_cfg_reg;

    // Mode and ratio settings shared by the front and back parts.
    typedef struct packed {
        logic               en_red;
        logic               en_green;
        logic               en_blue;
        logic               analog;
        logic [RATIO_W-1:0] ratio;
    } t_ctrl;

    // One mixed point, in half units, with its largest channel.
    typedef struct packed {
        logic [MIX_W-1:0] mr;
        logic [MIX_W-1:0] mg;
        logic [MIX_W-1:0] mb;
        logic [MIX_W-1:0] mx;
    } t_mix;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

FILE: rtl/core/lcca_front.sv
// Front part: accepts a point, folds disabled channels into enabled ones
// and finds the largest mixed channel. Depends on lcca_pkg.
module lcca_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lcca_pkg::t_ctrl             i_ctrl,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lcca_pkg::PIX_W-1:0]  i_red_in,
    input  logic [lcca_pkg::PIX_W-1:0]  i_green_in,
    input  logic [lcca_pkg::PIX_W-1:0]  i_blue_in,
    input  lcca_pkg::t_q_stat           i_q_stat,
    output logic                        o_push,
    output lcca_pkg::t_mix              o_push_data
);

    logic                r_f_valid;
    logic                n_f_valid;
    lcca_pkg::t_mix      r_f_data;
    lcca_pkg::t_mix      n_f_data;
    logic                w_accept;
    logic [lcca_pkg::MIX_W-1:0] w_spill;
    logic [lcca_pkg::MIX_W-1:0] w_r2;
    logic [lcca_pkg::MIX_W-1:0] w_g2;
    logic [lcca_pkg::MIX_W-1:0] w_b2;
    logic [lcca_pkg::MIX_W-1:0] w_mx;

    assign o_in_ready  = !r_f_valid || !i_q_stat.full;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_push      = r_f_valid && !i_q_stat.full;
    assign o_push_data = r_f_data;

    always_comb begin
        w_r2 = {1'b0, i_red_in, 1'b0};
        w_g2 = {1'b0, i_green_in, 1'b0};
        w_b2 = {1'b0, i_blue_in, 1'b0};
        // A disabled channel gives half its value to each enabled channel.
        w_spill = (i_ctrl.en_red   ? '0 : {2'b00, i_red_in})
                + (i_ctrl.en_green ? '0 : {2'b00, i_green_in})
                + (i_ctrl.en_blue  ? '0 : {2'b00, i_blue_in});
        n_f_data.mr = i_ctrl.en_red   ? w_r2 + w_spill : '0;
        n_f_data.mg = i_ctrl.en_green ? w_g2 + w_spill : '0;
        n_f_data.mb = i_ctrl.en_blue  ? w_b2 + w_spill : '0;
        w_mx = n_f_data.mr;
        if (n_f_data.mb > w_mx) begin
            w_mx = n_f_data.mb;
        end
        if (n_f_data.mg > w_mx) begin
            w_mx = n_f_data.mg;
        end
        n_f_data.mx = w_mx;

        if (w_accept) begin
            n_f_valid = 1'b1;
        end else if (o_push) begin
            n_f_valid = 1'b0;
        end else begin
            n_f_valid = r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_data <= n_f_data;
        end
    end

endmodule

FILE: rtl/core/lcca_queue.sv
// Short queue between the front and back parts, holding mixed points.
// Depends on lcca_pkg.
module lcca_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcca_pkg::t_mix    i_push_data,
    input  logic              i_pop,
    output lcca_pkg::t_mix    o_head,
    output lcca_pkg::t_q_stat o_stat
);

    localparam int DEPTH = lcca_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcca_pkg::t_mix   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: rtl/core/lcca_back.sv
// Back part: five-stage pipeline for gain, brightness ratio, luminance
// and clamping, ending in the output register. Depends on lcca_pkg.
module lcca_back #(
    parameter int GAIN_FRAC_BITS = lcca_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcca_pkg::t_ctrl               i_ctrl,
    input  logic [GAIN_FRAC_BITS+1:0]     i_gain_red,
    input  logic [GAIN_FRAC_BITS+1:0]     i_gain_green,
    input  logic [GAIN_FRAC_BITS+1:0]     i_gain_blue,
    input  lcca_pkg::t_q_stat             i_q_stat,
    input  lcca_pkg::t_mix                i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lcca_pkg::PIX_W-1:0]    o_red_out,
    output logic [lcca_pkg::PIX_W-1:0]    o_green_out,
    output logic [lcca_pkg::PIX_W-1:0]    o_blue_out,
    output logic [lcca_pkg::PIX_W-1:0]    o_gray_out
);

    localparam int GW    = GAIN_FRAC_BITS + 2;
    localparam int MW    = lcca_pkg::MIX_W;
    localparam int PW    = MW + GW;                    // mixed channel times gain
    localparam int SW    = lcca_pkg::RATIO_W + MW + 2; // ratio term times maximum
    localparam int VW    = PW + 10;                    // adjusted channel, signed
    localparam int LW    = VW + 12;                    // weighted channel and sum
    localparam int SHIFT = 9 + GAIN_FRAC_BITS;
    localparam int QW    = lcca_pkg::QUO_W;
    localparam int DW    = QW + lcca_pkg::RECIP_W;
    localparam int NS    = lcca_pkg::BACK_STAGES;
    localparam int PXW   = lcca_pkg::PIX_W;

    logic [NS-1:0]        r_vld;
    logic                 w_en;

    // Stage 1
    logic [PW-1:0]        r_p_r, r_p_g, r_p_b;
    logic signed [SW-1:0] r_sub;
    logic signed [lcca_pkg::RATIO_W:0] w_coef;
    logic signed [SW-1:0] n_sub;
    // Stage 2
    logic signed [VW-1:0] r_v_r, r_v_g, r_v_b;
    logic signed [VW-1:0] w_sub_s;
    // Stage 3
    logic signed [LW-1:0] r_l_r, r_l_g, r_l_b;
    logic [PXW-1:0]       r_c3_r, r_c3_g, r_c3_b;
    // Stage 4
    logic signed [LW-1:0] w_lum;
    logic signed [LW-1:0] w_q;
    logic                 r_pos;
    logic                 r_sat;
    logic [QW-1:0]        r_quo;
    logic [PXW-1:0]       r_c4_r, r_c4_g, r_c4_b;
    // Stage 5
    logic [DW-1:0]        w_div;
    logic [PXW-1:0]       n_gray;
    logic [PXW-1:0]       r_red, r_green, r_blue, r_gray;

    function automatic logic [PXW-1:0] chan_out(input logic signed [VW-1:0] v,
                                                input logic analog);
        logic signed [VW-1:0] vs;
        logic [PXW-1:0]       res;
        vs = v >>> SHIFT;
        if (!analog) begin
            res = (v > $signed(VW'(0))) ? lcca_pkg::PIX_MAX : '0;
        end else if (v <= $signed(VW'(0))) begin
            res = '0;
        end else if (vs > $signed(VW'(lcca_pkg::PIX_MAX))) begin
            res = lcca_pkg::PIX_MAX;
        end else begin
            res = vs[PXW-1:0];
        end
        return res;
    endfunction

    // The whole pipeline advances unless the output register holds a result
    // that is not being taken.
    assign w_en        = !r_vld[NS-1] || i_out_ready;
    assign o_pop       = !i_q_stat.empty && w_en;
    assign o_out_valid = r_vld[NS-1];
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_gray_out  = r_gray;

    always_comb begin
        w_coef  = $signed({1'b0, lcca_pkg::RATIO_ONE}) - $signed({1'b0, i_ctrl.ratio});
        n_sub   = SW'(w_coef) * $signed(SW'({1'b0, i_head.mx}));
        w_sub_s = VW'(r_sub) <<< GAIN_FRAC_BITS;
        w_lum   = r_l_r + r_l_g + r_l_b;
        w_q     = w_lum >>> SHIFT;
        w_div   = DW'(r_quo) * DW'(lcca_pkg::DIV_RECIP);
        if (!i_ctrl.analog) begin
            n_gray = r_pos ? lcca_pkg::PIX_MAX : '0;
        end else if (!r_pos) begin
            n_gray = '0;
        end else if (r_sat) begin
            n_gray = lcca_pkg::PIX_MAX;
        end else begin
            n_gray = w_div[lcca_pkg::DIV_SHIFT +: PXW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_r <= {{GW{1'b0}}, i_head.mr} * {{MW{1'b0}}, i_gain_red};
            r_p_g <= {{GW{1'b0}}, i_head.mg} * {{MW{1'b0}}, i_gain_green};
            r_p_b <= {{GW{1'b0}}, i_head.mb} * {{MW{1'b0}}, i_gain_blue};
            r_sub <= n_sub;

            r_v_r <= $signed({2'b00, r_p_r, 8'd0}) - w_sub_s;
            r_v_g <= $signed({2'b00, r_p_g, 8'd0}) - w_sub_s;
            r_v_b <= $signed({2'b00, r_p_b, 8'd0}) - w_sub_s;

            r_l_r  <= LW'(r_v_r) * $signed(LW'({1'b0, lcca_pkg::LUMA_R}));
            r_l_g  <= LW'(r_v_g) * $signed(LW'({1'b0, lcca_pkg::LUMA_G}));
            r_l_b  <= LW'(r_v_b) * $signed(LW'({1'b0, lcca_pkg::LUMA_B}));
            r_c3_r <= chan_out(r_v_r, i_ctrl.analog);
            r_c3_g <= chan_out(r_v_g, i_ctrl.analog);
            r_c3_b <= chan_out(r_v_b, i_ctrl.analog);

            r_pos  <= w_lum > $signed(LW'(0));
            r_sat  <= w_q >= $signed(LW'(lcca_pkg::DIV_SAT));
            r_quo  <= w_q[QW-1:0];
            r_c4_r <= r_c3_r;
            r_c4_g <= r_c3_g;
            r_c4_b <= r_c3_b;

            r_red   <= r_c4_r;
            r_green <= r_c4_g;
            r_blue  <= r_c4_b;
            r_gray  <= n_gray;
        end
    end

endmodule

FILE: rtl/core/laser_color_channel_adjust_unit.sv
// Top level of the laser color channel adjust unit: configuration registers,
// front mixer, point queue and back pipeline. Depends on lcca_pkg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready    | i_red_in, i_green_in, i_blue_in
//  out     | o_out_valid / i_out_ready  | o_red_out, o_green_out, o_blue_out,
//          |                            | o_gray_out
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One point per cycle sustained while the output is not stalled. The accepting
// edge loads the front register; the point then passes through a queue slot and
// the five back stages and ends in the output register. Reset is synchronous
// and active low; it empties the pipeline and loads the register defaults. A
// stall at the output freezes the back pipeline, the queue fills, and the input
// ready drops once front register and queue are full. Configuration writes are
// always taken.
module laser_color_channel_adjust_unit #(
    parameter int GAIN_FRAC_BITS = lcca_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lcca_pkg::PIX_W-1:0]        i_red_in,
    input  logic [lcca_pkg::PIX_W-1:0]        i_green_in,
    input  logic [lcca_pkg::PIX_W-1:0]        i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lcca_pkg::PIX_W-1:0]        o_red_out,
    output logic [lcca_pkg::PIX_W-1:0]        o_green_out,
    output logic [lcca_pkg::PIX_W-1:0]        o_blue_out,
    output logic [lcca_pkg::PIX_W-1:0]        o_gray_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcca_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [((GAIN_FRAC_BITS + 2 > lcca_pkg::RATIO_W) ?
                   GAIN_FRAC_BITS + 2 : lcca_pkg::RATIO_W)-1:0] i_cfg_data
);

    localparam int GW = GAIN_FRAC_BITS + 2;
    localparam logic [GW-1:0] GAIN_ONE = {2'b01, {GAIN_FRAC_BITS{1'b0}}};

    lcca_pkg::t_ctrl   r_ctrl;
    logic [GW-1:0]     r_gain_red;
    logic [GW-1:0]     r_gain_green;
    logic [GW-1:0]     r_gain_blue;
    logic              w_cfg_wr;

    lcca_pkg::t_q_stat w_q_stat;
    logic              w_push;
    lcca_pkg::t_mix    w_push_data;
    logic              w_pop;
    lcca_pkg::t_mix    w_head;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.en_red   <= 1'b1;
            r_ctrl.en_green <= 1'b1;
            r_ctrl.en_blue  <= 1'b1;
            r_ctrl.analog   <= 1'b1;
            r_ctrl.ratio    <= lcca_pkg::RATIO_ONE;
            r_gain_red      <= GAIN_ONE;
            r_gain_green    <= GAIN_ONE;
            r_gain_blue     <= GAIN_ONE;
        end else if (w_cfg_wr) begin
            case (lcca_pkg::t_cfg_reg'(i_cfg_index))
                lcca_pkg::CFG_EN_RED:     r_ctrl.en_red   <= i_cfg_data[0];
                lcca_pkg::CFG_EN_GREEN:   r_ctrl.en_green <= i_cfg_data[0];
                lcca_pkg::CFG_EN_BLUE:    r_ctrl.en_blue  <= i_cfg_data[0];
                lcca_pkg::CFG_ANALOG:     r_ctrl.analog   <= i_cfg_data[0];
                lcca_pkg::CFG_GAIN_RED:   r_gain_red      <= i_cfg_data[GW-1:0];
                lcca_pkg::CFG_GAIN_GREEN: r_gain_green    <= i_cfg_data[GW-1:0];
                lcca_pkg::CFG_GAIN_BLUE:  r_gain_blue     <= i_cfg_data[GW-1:0];
                lcca_pkg::CFG_RATIO: begin
                    r_ctrl.ratio <= i_cfg_data[lcca_pkg::RATIO_W-1:0];
                end
                default: ;
            endcase
        end
    end

    lcca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (r_ctrl),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    lcca_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    lcca_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (r_ctrl),
        .i_gain_red   (r_gain_red),
        .i_gain_green (r_gain_green),
        .i_gain_blue  (r_gain_blue),
        .i_q_stat     (w_q_stat),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_gray_out   (o_gray_out)
    );

endmodule

FILE: rtl/core/lcca_checker.sv
// Port checker for the laser color channel adjust unit, with its bind.
// Depends on lcca_pkg and laser_color_channel_adjust_unit.
module lcca_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [lcca_pkg::PIX_W-1:0] o_red_out,
    input logic [lcca_pkg::PIX_W-1:0] o_green_out,
    input logic [lcca_pkg::PIX_W-1:0] o_blue_out,
    input logic [lcca_pkg::PIX_W-1:0] o_gray_out
);

    localparam int CNT_W = $clog2(lcca_pkg::PIPE_CAPACITY + 2);

    logic [CNT_W-1:0] r_inflight;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Points accepted whose results have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (!w_in_acc && w_out_acc && r_inflight != '0) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_gray_out))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != '0)
        else $error("result shown without an accepted point");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(lcca_pkg::PIPE_CAPACITY))
        else $error("more points held than the pipeline can store");

endmodule

bind laser_color_channel_adjust_unit lcca_checker u_lcca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_gray_out  (o_gray_out)
);
